/* rtl/osmc_pkg.sv */
// Shared types and constants of the obstacle-stop motor controller.
package osmc_pkg;

   // Field widths fixed by the item and register layout.
   localparam int ECHO_W     = 15;
   localparam int POT_W      = 10;
   localparam int DUTY_W     = 8;
   localparam int ANGLE_W    = 7;
   localparam int TONE_W     = 2;
   localparam int EVENT_W    = 3;
   localparam int DIR_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int COUNT_W    = 6;

   // Most result items one input item may cause.
   localparam logic [COUNT_W-1:0] MAX_RESULTS = 6'd52;

   // Full-scale potentiometer reading.
   localparam logic [POT_W:0] POT_FULL = 11'd1023;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_ECHO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ECHO   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_SPEED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP  = 2'd3;

   // Register reset values (2 cm and 40 cm as echo widths in microseconds).
   localparam logic [ECHO_W-1:0] NEAR_ECHO_RESET  = 15'd2352;
   localparam logic [ECHO_W-1:0] MIN_ECHO_RESET   = 15'd118;
   localparam logic [DUTY_W-1:0] SIDE_SPEED_RESET = 8'd100;
   localparam logic [DUTY_W-1:0] RAMP_STEP_RESET  = 8'd5;

   // Buzzer codes.
   localparam logic [TONE_W-1:0] TONE_NONE     = 2'd0;
   localparam logic [TONE_W-1:0] TONE_OBSTACLE = 2'd1;
   localparam logic [TONE_W-1:0] TONE_CLEARED  = 2'd2;

   // Event codes.
   localparam logic [EVENT_W-1:0] EV_ON      = 3'd1;
   localparam logic [EVENT_W-1:0] EV_OFF     = 3'd2;
   localparam logic [EVENT_W-1:0] EV_FRONT   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_SIDE    = 3'd4;
   localparam logic [EVENT_W-1:0] EV_CLEARED = 3'd5;
   localparam logic [EVENT_W-1:0] EV_SPEED   = 3'd6;

   // Servo angles in degrees.
   localparam logic [ANGLE_W-1:0] SERVO_PARK  = 7'd0;
   localparam logic [ANGLE_W-1:0] SERVO_SIDE  = 7'd45;
   localparam logic [ANGLE_W-1:0] SERVO_FRONT = 7'd90;

   // Direction pins: bit 0 forward, bit 1 reverse.
   localparam logic [DIR_W-1:0] DIR_STOP    = 2'b00;
   localparam logic [DIR_W-1:0] DIR_FORWARD = 2'b01;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_EVAL,
      OP_PLAN,
      OP_TOGGLE,
      OP_RAMP,
      OP_CLEAR,
      OP_SPEED
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PLAN,
      ST_TOGGLE,
      ST_RAMP,
      ST_CLEAR,
      ST_SPEED
   } state_type;

   // Status reported by the datapath to the controller.
   typedef struct packed {
      logic toggled;
      logic new_obstacle;
      logic cleared;
      logic speed_set;
      logic ramp_more;
      logic out_free;
   } status_type;

endpackage

/* rtl/osmc_datapath.sv */
// Datapath: registers, obstacle detection, speed scaling, ramp and result register.
module osmc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  osmc_pkg::op_type                       op,
   output osmc_pkg::status_type                   status,
   input  logic                                   req_button_level,
   input  logic [osmc_pkg::ECHO_W-1:0]            req_echo_front,
   input  logic [osmc_pkg::ECHO_W-1:0]            req_echo_side_a,
   input  logic [osmc_pkg::ECHO_W-1:0]            req_echo_side_b,
   input  logic [osmc_pkg::POT_W-1:0]             req_pot_level,
   input  logic                                   csr_write,
   input  logic [osmc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [osmc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [osmc_pkg::DUTY_W-1:0]            rsp_pwm_duty,
   output logic                                   rsp_drive_forward,
   output logic                                   rsp_drive_reverse,
   output logic [osmc_pkg::ANGLE_W-1:0]           rsp_servo_angle,
   output logic [osmc_pkg::TONE_W-1:0]            rsp_tone_code,
   output logic [osmc_pkg::EVENT_W-1:0]           rsp_event_code,
   output logic                                   rsp_enabled,
   output logic                                   rsp_last
);

   // Configuration registers.
   logic [osmc_pkg::ECHO_W-1:0] near_echo_ff, near_echo_in;
   logic [osmc_pkg::ECHO_W-1:0] min_echo_ff, min_echo_in;
   logic [osmc_pkg::DUTY_W-1:0] side_speed_ff, side_speed_in;
   logic [osmc_pkg::DUTY_W-1:0] ramp_step_ff, ramp_step_in;

   // Controller state of the block.
   logic                        sys_en_ff, sys_en_in;
   logic                        prev_button_ff, prev_button_in;
   logic                        prev_obs_ff, prev_obs_in;
   logic                        lock_ff, lock_in;
   logic [osmc_pkg::DUTY_W-1:0] speed_mem_ff, speed_mem_in;
   logic [osmc_pkg::DUTY_W-1:0] pwm_ff, pwm_in;
   logic [osmc_pkg::DIR_W-1:0]  dir_ff, dir_in;
   logic [osmc_pkg::ANGLE_W-1:0] servo_ff, servo_in;

   // Latched input item.
   logic                        btn_ff, btn_in;
   logic [osmc_pkg::ECHO_W-1:0] echo_f_ff, echo_f_in;
   logic [osmc_pkg::ECHO_W-1:0] echo_a_ff, echo_a_in;
   logic [osmc_pkg::ECHO_W-1:0] echo_b_ff, echo_b_in;
   logic [osmc_pkg::POT_W-1:0]  pot_ff, pot_in;

   // Per-item decisions.
   logic                        toggled_ff, toggled_in;
   logic                        front_ff, front_in;
   logic                        side_ff, side_in;
   logic [osmc_pkg::DUTY_W-1:0] speed_ff, speed_in;
   logic                        new_obs_ff, new_obs_in;
   logic                        cleared_ff, cleared_in;
   logic                        speed_set_ff, speed_set_in;
   logic                        ramp_first_ff, ramp_first_in;
   logic [osmc_pkg::DUTY_W-1:0] ramp_s_ff, ramp_s_in;
   logic [osmc_pkg::DUTY_W-1:0] ramp_t_ff, ramp_t_in;
   logic [osmc_pkg::COUNT_W-1:0] count_ff, count_in;

   // Result register.
   logic                          out_valid_ff, out_valid_in;
   logic [osmc_pkg::DUTY_W-1:0]   out_pwm_ff, out_pwm_in;
   logic [osmc_pkg::DIR_W-1:0]    out_dir_ff, out_dir_in;
   logic [osmc_pkg::ANGLE_W-1:0]  out_servo_ff, out_servo_in;
   logic [osmc_pkg::TONE_W-1:0]   out_tone_ff, out_tone_in;
   logic [osmc_pkg::EVENT_W-1:0]  out_event_ff, out_event_in;
   logic                          out_en_ff, out_en_in;
   logic                          out_last_ff, out_last_in;

   // Combinational helpers.
   logic                          falling;
   logic                          obstacle;
   logic                          out_free;
   logic                          emit;
   logic [osmc_pkg::DUTY_W-1:0]   step_eff;
   logic                          ramp_write;
   logic                          ramp_more;
   logic [osmc_pkg::DUTY_W:0]     ramp_limit;
   logic [osmc_pkg::POT_W+7:0]    pot_x;
   logic [osmc_pkg::DUTY_W-1:0]   quot0;
   logic [osmc_pkg::POT_W:0]      rem0;
   logic [osmc_pkg::DUTY_W-1:0]   speed_q;

   // An echo counts as an obstacle when it lies between the two limits.
   function automatic logic echo_hit(input logic [osmc_pkg::ECHO_W-1:0] echo,
                                     input logic [osmc_pkg::ECHO_W-1:0] lo,
                                     input logic [osmc_pkg::ECHO_W-1:0] hi);
      echo_hit = (echo >= lo) && (echo <= hi);
   endfunction

   // Configuration writes.
   always_comb begin
      near_echo_in  = near_echo_ff;
      min_echo_in   = min_echo_ff;
      side_speed_in = side_speed_ff;
      ramp_step_in  = ramp_step_ff;
      if (csr_write) begin
         unique case (csr_index)
            osmc_pkg::CSR_NEAR_ECHO:  near_echo_in  = csr_wdata;
            osmc_pkg::CSR_MIN_ECHO:   min_echo_in   = csr_wdata;
            osmc_pkg::CSR_SIDE_SPEED: side_speed_in = csr_wdata[osmc_pkg::DUTY_W-1:0];
            osmc_pkg::CSR_RAMP_STEP:  ramp_step_in  = csr_wdata[osmc_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // Speed = pot * 255 / 1023: the quotient by 1024 is low by at most one.
   always_comb begin
      pot_x   = {pot_ff, 8'b0} - {8'b0, pot_ff};
      quot0   = pot_x[osmc_pkg::POT_W+7:osmc_pkg::POT_W];
      rem0    = {1'b0, pot_x[osmc_pkg::POT_W-1:0]} + {3'b0, quot0};
      speed_q = (rem0 >= osmc_pkg::POT_FULL) ? quot0 + 8'd1 : quot0;
   end

   // Ramp bookkeeping: a further write exists while the next value stays at or
   // above the target and the result limit is not reached.
   always_comb begin
      falling    = !btn_ff && prev_button_ff;
      obstacle   = front_ff || side_ff;
      step_eff   = (ramp_step_ff == '0) ? 8'd1 : ramp_step_ff;
      ramp_write = ramp_s_ff >= ramp_t_ff;
      ramp_limit = {1'b0, ramp_t_ff} + {1'b0, step_eff};
      ramp_more  = ramp_write && ({1'b0, ramp_s_ff} >= ramp_limit) &&
                   (count_ff < osmc_pkg::MAX_RESULTS - 6'd1);
      out_free   = !out_valid_ff || rsp_ready;
   end

   // Operation decode: next state of the block and the result item.
   always_comb begin
      sys_en_in      = sys_en_ff;
      prev_button_in = prev_button_ff;
      prev_obs_in    = prev_obs_ff;
      lock_in        = lock_ff;
      speed_mem_in   = speed_mem_ff;
      pwm_in         = pwm_ff;
      dir_in         = dir_ff;
      servo_in       = servo_ff;
      btn_in         = btn_ff;
      echo_f_in      = echo_f_ff;
      echo_a_in      = echo_a_ff;
      echo_b_in      = echo_b_ff;
      pot_in         = pot_ff;
      toggled_in     = toggled_ff;
      front_in       = front_ff;
      side_in        = side_ff;
      speed_in       = speed_ff;
      new_obs_in     = new_obs_ff;
      cleared_in     = cleared_ff;
      speed_set_in   = speed_set_ff;
      ramp_first_in  = ramp_first_ff;
      ramp_s_in      = ramp_s_ff;
      ramp_t_in      = ramp_t_ff;
      count_in       = count_ff;
      emit           = 1'b0;
      out_tone_in    = osmc_pkg::TONE_NONE;
      out_event_in   = osmc_pkg::EV_ON;
      out_last_in    = 1'b1;

      unique case (op)
         osmc_pkg::OP_NONE: ;
         osmc_pkg::OP_LOAD: begin
            btn_in    = req_button_level;
            echo_f_in = req_echo_front;
            echo_a_in = req_echo_side_a;
            echo_b_in = req_echo_side_b;
            pot_in    = req_pot_level;
            count_in  = '0;
         end
         osmc_pkg::OP_EVAL: begin
            // Button edge, sensor checks and speed scaling.
            prev_button_in = btn_ff;
            toggled_in     = falling;
            sys_en_in      = sys_en_ff ^ falling;
            if (falling && sys_en_ff) begin
               servo_in    = osmc_pkg::SERVO_PARK;
               dir_in      = osmc_pkg::DIR_STOP;
               pwm_in      = '0;
               lock_in     = 1'b0;
               prev_obs_in = 1'b0;
            end
            front_in = echo_hit(echo_f_ff, min_echo_ff, near_echo_ff);
            side_in  = echo_hit(echo_a_ff, min_echo_ff, near_echo_ff) ||
                       echo_hit(echo_b_ff, min_echo_ff, near_echo_ff);
            speed_in = speed_q;
         end
         osmc_pkg::OP_PLAN: begin
            // Choose the actions for this item; the lock is free once cleared.
            new_obs_in   = sys_en_ff && obstacle && !prev_obs_ff;
            cleared_in   = sys_en_ff && !obstacle && prev_obs_ff;
            speed_set_in = sys_en_ff && !obstacle && (prev_obs_ff || !lock_ff) &&
                           ((speed_ff == '0) || (speed_ff != speed_mem_ff));
            if (sys_en_ff) begin
               prev_obs_in = obstacle;
            end
            ramp_first_in = 1'b1;
            ramp_s_in     = speed_mem_ff;
            ramp_t_in     = front_ff ? '0 : side_speed_ff;
         end
         osmc_pkg::OP_TOGGLE: begin
            emit         = 1'b1;
            out_event_in = sys_en_ff ? osmc_pkg::EV_ON : osmc_pkg::EV_OFF;
            out_last_in  = !(new_obs_ff || cleared_ff || speed_set_ff);
         end
         osmc_pkg::OP_RAMP: begin
            // One ramp item; the first one locks the motor and turns the servo.
            emit = 1'b1;
            if (ramp_first_ff) begin
               lock_in  = 1'b1;
               servo_in = front_ff ? osmc_pkg::SERVO_FRONT : osmc_pkg::SERVO_SIDE;
            end
            if (ramp_write) begin
               pwm_in = ramp_s_ff;
            end
            out_tone_in   = ramp_first_ff ? osmc_pkg::TONE_OBSTACLE : osmc_pkg::TONE_NONE;
            out_event_in  = front_ff ? osmc_pkg::EV_FRONT : osmc_pkg::EV_SIDE;
            out_last_in   = !ramp_more;
            ramp_s_in     = ramp_s_ff - step_eff;
            ramp_first_in = 1'b0;
            if (!ramp_more) begin
               speed_mem_in = ramp_t_ff;
            end
         end
         osmc_pkg::OP_CLEAR: begin
            emit         = 1'b1;
            lock_in      = 1'b0;
            servo_in     = osmc_pkg::SERVO_PARK;
            out_tone_in  = osmc_pkg::TONE_CLEARED;
            out_event_in = osmc_pkg::EV_CLEARED;
            out_last_in  = !speed_set_ff;
         end
         osmc_pkg::OP_SPEED: begin
            emit         = 1'b1;
            out_event_in = osmc_pkg::EV_SPEED;
            if (speed_ff == '0) begin
               dir_in = osmc_pkg::DIR_STOP;
               pwm_in = '0;
            end else begin
               dir_in       = osmc_pkg::DIR_FORWARD;
               pwm_in       = speed_ff;
               speed_mem_in = speed_ff;
            end
         end
         default: ;
      endcase

      // The result item shows the state after its own update.
      out_pwm_in   = pwm_in;
      out_dir_in   = dir_in;
      out_servo_in = servo_in;
      out_en_in    = sys_en_in;
      if (emit) begin
         count_in     = count_ff + 6'd1;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         near_echo_ff   <= osmc_pkg::NEAR_ECHO_RESET;
         min_echo_ff    <= osmc_pkg::MIN_ECHO_RESET;
         side_speed_ff  <= osmc_pkg::SIDE_SPEED_RESET;
         ramp_step_ff   <= osmc_pkg::RAMP_STEP_RESET;
         sys_en_ff      <= 1'b0;
         prev_button_ff <= 1'b0;
         prev_obs_ff    <= 1'b0;
         lock_ff        <= 1'b0;
         speed_mem_ff   <= '0;
         pwm_ff         <= '0;
         dir_ff         <= osmc_pkg::DIR_STOP;
         servo_ff       <= osmc_pkg::SERVO_PARK;
         toggled_ff     <= 1'b0;
         new_obs_ff     <= 1'b0;
         cleared_ff     <= 1'b0;
         speed_set_ff   <= 1'b0;
         ramp_first_ff  <= 1'b0;
         count_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         near_echo_ff   <= near_echo_in;
         min_echo_ff    <= min_echo_in;
         side_speed_ff  <= side_speed_in;
         ramp_step_ff   <= ramp_step_in;
         sys_en_ff      <= sys_en_in;
         prev_button_ff <= prev_button_in;
         prev_obs_ff    <= prev_obs_in;
         lock_ff        <= lock_in;
         speed_mem_ff   <= speed_mem_in;
         pwm_ff         <= pwm_in;
         dir_ff         <= dir_in;
         servo_ff       <= servo_in;
         toggled_ff     <= toggled_in;
         new_obs_ff     <= new_obs_in;
         cleared_ff     <= cleared_in;
         speed_set_ff   <= speed_set_in;
         ramp_first_ff  <= ramp_first_in;
         count_ff       <= count_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      btn_ff    <= btn_in;
      echo_f_ff <= echo_f_in;
      echo_a_ff <= echo_a_in;
      echo_b_ff <= echo_b_in;
      pot_ff    <= pot_in;
      front_ff  <= front_in;
      side_ff   <= side_in;
      speed_ff  <= speed_in;
      ramp_s_ff <= ramp_s_in;
      ramp_t_ff <= ramp_t_in;
      if (emit) begin
         out_pwm_ff   <= out_pwm_in;
         out_dir_ff   <= out_dir_in;
         out_servo_ff <= out_servo_in;
         out_tone_ff  <= out_tone_in;
         out_event_ff <= out_event_in;
         out_en_ff    <= out_en_in;
         out_last_ff  <= out_last_in;
      end
   end

   // Status and result ports.
   assign status.toggled      = toggled_ff;
   assign status.new_obstacle = new_obs_ff;
   assign status.cleared      = cleared_ff;
   assign status.speed_set    = speed_set_ff;
   assign status.ramp_more    = ramp_more;
   assign status.out_free     = out_free;

   assign rsp_valid         = out_valid_ff;
   assign rsp_pwm_duty      = out_pwm_ff;
   assign rsp_drive_forward = out_dir_ff[0];
   assign rsp_drive_reverse = out_dir_ff[1];
   assign rsp_servo_angle   = out_servo_ff;
   assign rsp_tone_code     = out_tone_ff;
   assign rsp_event_code    = out_event_ff;
   assign rsp_enabled       = out_en_ff;
   assign rsp_last          = out_last_ff;

endmodule

/* rtl/osmc_ctrl.sv */
// Controller: sequences one item through evaluation and its result items.
module osmc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  osmc_pkg::status_type  status,
   output osmc_pkg::op_type      op
);

   osmc_pkg::state_type state_ff, state_in;
   osmc_pkg::state_type after_toggle;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= osmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath operation.
   always_comb begin
      state_in  = state_ff;
      op        = osmc_pkg::OP_NONE;
      req_ready = 1'b0;

      // First action after the on/off item.
      priority if (status.new_obstacle) begin
         after_toggle = osmc_pkg::ST_RAMP;
      end else if (status.cleared) begin
         after_toggle = osmc_pkg::ST_CLEAR;
      end else if (status.speed_set) begin
         after_toggle = osmc_pkg::ST_SPEED;
      end else begin
         after_toggle = osmc_pkg::ST_IDLE;
      end

      unique case (state_ff)
         osmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = osmc_pkg::OP_LOAD;
               state_in = osmc_pkg::ST_EVAL;
            end
         end
         osmc_pkg::ST_EVAL: begin
            op       = osmc_pkg::OP_EVAL;
            state_in = osmc_pkg::ST_PLAN;
         end
         osmc_pkg::ST_PLAN: begin
            op       = osmc_pkg::OP_PLAN;
            state_in = osmc_pkg::ST_TOGGLE;
         end
         osmc_pkg::ST_TOGGLE: begin
            if (!status.toggled) begin
               state_in = after_toggle;
            end else if (status.out_free) begin
               op       = osmc_pkg::OP_TOGGLE;
               state_in = after_toggle;
            end
         end
         osmc_pkg::ST_RAMP: begin
            if (status.out_free) begin
               op = osmc_pkg::OP_RAMP;
               if (!status.ramp_more) begin
                  state_in = osmc_pkg::ST_IDLE;
               end
            end
         end
         osmc_pkg::ST_CLEAR: begin
            if (status.out_free) begin
               op       = osmc_pkg::OP_CLEAR;
               state_in = status.speed_set ? osmc_pkg::ST_SPEED : osmc_pkg::ST_IDLE;
            end
         end
         osmc_pkg::ST_SPEED: begin
            if (status.out_free) begin
               op       = osmc_pkg::OP_SPEED;
               state_in = osmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = osmc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/obstacle_stop_motor_controller.sv */
// Top level of the obstacle-stop motor controller.
//
// Usage: each req_ item is one control-loop sample (button level, three echo
// widths, potentiometer reading). The block answers with zero to 52 rsp_
// items; rsp_last marks the final item of a sample. Registers are written on
// the csr_ channel (index 0 near echo limit, 1 minimum echo, 2 side speed,
// 3 ramp step), which is always ready; write them only while the block idles.
// Each sample is taken, evaluated in the EVAL state and sorted in PLAN;
// the on/off item, if any, and then the other result items follow. The ramp
// sequencer, one drive step per cycle while the output register is free,
// gives the longest run of result items.
// The next sample is taken once the last result of the current one is in the
// output register; req_ready is high only while the controller idles.
// A stalled receiver holds the output register, and the sequencer waits.
// Reset (synchronous, active high) restores the register defaults, turns the
// block off, parks the servo and stops the motor.
module obstacle_stop_motor_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_button_level,
   input  logic [osmc_pkg::ECHO_W-1:0]            req_echo_front,
   input  logic [osmc_pkg::ECHO_W-1:0]            req_echo_side_a,
   input  logic [osmc_pkg::ECHO_W-1:0]            req_echo_side_b,
   input  logic [osmc_pkg::POT_W-1:0]             req_pot_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [osmc_pkg::DUTY_W-1:0]            rsp_pwm_duty,
   output logic                                   rsp_drive_forward,
   output logic                                   rsp_drive_reverse,
   output logic [osmc_pkg::ANGLE_W-1:0]           rsp_servo_angle,
   output logic [osmc_pkg::TONE_W-1:0]            rsp_tone_code,
   output logic [osmc_pkg::EVENT_W-1:0]           rsp_event_code,
   output logic                                   rsp_enabled,
   output logic                                   rsp_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [osmc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [osmc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   osmc_pkg::op_type     ctrl_op;
   osmc_pkg::status_type dp_status;

   // Register writes are taken in any cycle.
   assign csr_ready = 1'b1;

   // Sequencer.
   osmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .op        (ctrl_op)
   );

   // Datapath and result register.
   osmc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .op                (ctrl_op),
      .status            (dp_status),
      .req_button_level  (req_button_level),
      .req_echo_front    (req_echo_front),
      .req_echo_side_a   (req_echo_side_a),
      .req_echo_side_b   (req_echo_side_b),
      .req_pot_level     (req_pot_level),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pwm_duty      (rsp_pwm_duty),
      .rsp_drive_forward (rsp_drive_forward),
      .rsp_drive_reverse (rsp_drive_reverse),
      .rsp_servo_angle   (rsp_servo_angle),
      .rsp_tone_code     (rsp_tone_code),
      .rsp_event_code    (rsp_event_code),
      .rsp_enabled       (rsp_enabled),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTHESIS
   // An accepted item is evaluated in the very next cycle.
   a_accept_then_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (ctrl_op == osmc_pkg::OP_EVAL))
      else $error("accepted item not evaluated in the next cycle");

   // A result item is only produced when the output register can take it.
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (ctrl_op == osmc_pkg::OP_TOGGLE || ctrl_op == osmc_pkg::OP_RAMP ||
       ctrl_op == osmc_pkg::OP_CLEAR || ctrl_op == osmc_pkg::OP_SPEED)
      |-> dp_status.out_free)
      else $error("result item produced while the output register is full");

   // The final ramp item ends the ramp.
   a_ramp_ends: assert property (@(posedge clock) disable iff (reset)
      (ctrl_op == osmc_pkg::OP_RAMP && !dp_status.ramp_more)
      |=> (ctrl_op != osmc_pkg::OP_RAMP))
      else $error("ramp continued after its final item");
`endif

endmodule
